[rtl/brainfuck_execution_core_defines.svh]
// Assertion macros shared by the execution core modules.
`ifndef BRAINFUCK_EXECUTION_CORE_DEFINES_SVH
`define BRAINFUCK_EXECUTION_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define BFC_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define BFC_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[rtl/bfc_pkg.sv]
// Types, constants and helpers shared by the execution core modules.
package bfc_pkg;

  localparam int TAPE_DEPTH  = 32768;
  localparam int STACK_DEPTH = 64;

  localparam int PTR_W = $clog2(TAPE_DEPTH);
  localparam int LEN_W = $clog2(TAPE_DEPTH + 1);
  localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [SP_W-1:0]  sp_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_IN    = 8'h2C;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  localparam logic [15:0] TAPE_LENGTH_RESET = 16'd30000;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_OVERFLOW = 2'd1,
    FAULT_EMPTY    = 2'd2
  } fault_t;

  typedef struct packed {
    logic [7:0]  instruction;
    logic [15:0] position;
    logic [7:0]  input_byte;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_position;
    logic        out_valid;
    logic [7:0]  out_byte;
    fault_t      fault;
  } result_t;

  typedef struct packed {
    logic       rd_en;
    ptr_t       rd_addr;
    logic       wr_en;
    ptr_t       wr_addr;
    logic [7:0] wr_data;
  } tape_req_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [15:0] data;
  } stack_op_t;

  // Length in use: register value limited to 1..TAPE_DEPTH.
  function automatic len_t clamp_length(logic [15:0] n);
    logic [16:0] w;
    w = {1'b0, n};
    if (w == 17'd0) return len_t'(1);
    if (w > 17'(TAPE_DEPTH)) return len_t'(TAPE_DEPTH);
    return len_t'(w);
  endfunction

endpackage

[rtl/bfc_tape.sv]
// Tape memory with post-reset clearing sweep and write-to-read forwarding.
`include "brainfuck_execution_core_defines.svh"

module bfc_tape (
  input  logic              clk,
  input  logic              rst,
  input  bfc_pkg::tape_req_t req,
  output logic [7:0]        rd_data,
  output logic              busy
);
  import bfc_pkg::*;

  logic [7:0] mem [TAPE_DEPTH];
  logic [7:0] rdata_q;
  logic       fwd_hit;
  logic [7:0] fwd_data;
  ptr_t       clr_addr;
  logic       we;
  ptr_t       wa;
  logic [7:0] wd;

  always_comb begin
    if (busy) begin
      we = 1'b1;
      wa = clr_addr;
      wd = 8'd0;
    end else begin
      we = req.wr_en;
      wa = req.wr_addr;
      wd = req.wr_data;
    end
  end

  // read-before-write: a read and a write to one cell at one edge returns old data
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (req.rd_en) rdata_q <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req.rd_en) begin
      fwd_hit <= we && (wa == req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) fwd_data <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ptr_t'(1);
      if (clr_addr == ptr_t'(TAPE_DEPTH - 1)) busy <= 1'b0;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rdata_q;

  `BFC_NEVER(a_no_read_in_clear, clk, rst, busy && req.rd_en, "tape read during clear")
  `BFC_NEVER(a_no_write_in_clear, clk, rst, busy && req.wr_en, "tape write during clear")
  `BFC_CHECK(a_clear_full, clk, rst, $fell(busy) |-> ($past(clr_addr) == ptr_t'(TAPE_DEPTH - 1)), "clear ended early")

endmodule

[rtl/bfc_stack.sv]
// Loop-start stack: memory below a forwarded top entry, with fill count.
`include "brainfuck_execution_core_defines.svh"

module bfc_stack (
  input  logic               clk,
  input  logic               rst,
  input  bfc_pkg::stack_op_t op,
  output bfc_pkg::cnt_t      count,
  output logic [15:0]        top
);
  import bfc_pkg::*;

  logic [15:0] mem [STACK_DEPTH];
  logic [15:0] rdata_q;
  logic        fwd_valid;
  logic [15:0] fwd_data;
  cnt_t        count_next;
  sp_t         rd_addr;

  always_comb begin
    if (op.push) count_next = count + cnt_t'(1);
    else if (op.pop) count_next = count - cnt_t'(1);
    else count_next = count;
  end

  // always read the entry that will be on top after this edge
  assign rd_addr = sp_t'(count_next - cnt_t'(1));

  always_ff @(posedge clk) begin
    if (op.push) mem[sp_t'(count)] <= op.data;
    rdata_q <= mem[rd_addr];
  end

  // a push lands at the very address being read, so the old data is stale
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (op.push) fwd_valid <= 1'b1;
      else if (op.pop) fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) fwd_data <= op.data;
  end

  assign top = fwd_valid ? fwd_data : rdata_q;

  `BFC_NEVER(a_push_full, clk, rst, op.push && (count >= cnt_t'(STACK_DEPTH)), "push on full stack")
  `BFC_NEVER(a_pop_empty, clk, rst, op.pop && (count == '0), "pop on empty stack")
  `BFC_CHECK(a_push_step, clk, rst, op.push && !op.pop |=> (count == $past(count) + cnt_t'(1)), "push count")

endmodule

[rtl/brainfuck_execution_core.sv]
// Top level of the Brainfuck execution core: execute stage and result register.
//
// Usage:
//   instr channel: one fetched program character with its position and the ','
//   byte is transferred when instr_valid is high and instr_stall is low.
//   result channel: one result per instruction (next fetch position, output
//   byte for '.', fault code), transferred when result_valid is high and
//   result_stall is low. Results leave in instruction order.
//   cfg_we/cfg_wdata write tape_length; write only while the core is idle.
// Timing: an instruction is registered into the execute stage at transfer,
//   its result into the result register as that stage advances. Throughput
//   is one instruction per cycle unless the tape sweep or result_stall holds
//   the flow: each instruction does one tape read-modify-write, the read at
//   transfer, the write as it advances, the last write forwarded to the next read.
// Reset:
//   rst is synchronous. After it the tape is swept to zero, one cell a cycle,
//   across all TAPE_DEPTH (32768) cells; instr_stall stays high during the sweep.
// Back-pressure:
//   while result_stall holds a waiting result, one more instruction is taken
//   into the execute stage, then instr_stall rises until the result drains.
module brainfuck_execution_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  bfc_pkg::instr_t  instr,
  output logic             result_valid,
  input  logic             result_stall,
  output bfc_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);
  import bfc_pkg::*;

  len_t        used_len;
  logic        s1_valid;
  instr_t      s1;
  ptr_t        ptr;
  ptr_t        ptr_upd;
  len_t        ptr_ext;
  logic [15:0] skip_depth;
  logic [15:0] skip_next;
  logic [15:0] after;
  logic        skipping;
  logic [7:0]  cell_data;
  logic        tape_busy;
  logic        wr;
  logic [7:0]  wr_data;
  logic        push;
  logic        pop;
  tape_req_t   treq;
  stack_op_t   sop;
  cnt_t        stack_count;
  logic [15:0] stack_top;
  logic        accept;
  logic        s1_advance;
  result_t     res_next;

  assign s1_advance  = s1_valid && (!result_valid || !result_stall);
  assign instr_stall = tape_busy || (s1_valid && !s1_advance);
  assign accept      = instr_valid && !instr_stall;

  always_comb begin
    skipping  = (skip_depth != 16'd0);
    after     = s1.position + 16'd1;
    ptr_ext   = len_t'(ptr);
    ptr_upd   = ptr;
    skip_next = skip_depth;
    wr        = 1'b0;
    wr_data   = cell_data;
    push      = 1'b0;
    pop       = 1'b0;
    res_next.next_position = after;
    res_next.out_valid     = 1'b0;
    res_next.out_byte      = 8'd0;
    res_next.fault         = FAULT_NONE;
    if (s1_valid) begin
      if (skipping) begin
        if (s1.instruction == OP_OPEN) begin
          if (skip_depth != 16'hFFFF) skip_next = skip_depth + 16'd1;
        end else if (s1.instruction == OP_CLOSE) begin
          skip_next = skip_depth - 16'd1;
        end
      end else begin
        unique case (s1.instruction)
          OP_RIGHT: begin
            if (ptr_ext + len_t'(1) >= used_len) ptr_upd = '0;
            else ptr_upd = ptr + ptr_t'(1);
          end
          OP_LEFT: begin
            // pointer left past a lowered length goes to the last cell
            if (ptr == '0 || ptr_ext > used_len) ptr_upd = ptr_t'(used_len - len_t'(1));
            else ptr_upd = ptr - ptr_t'(1);
          end
          OP_INC: begin
            wr      = 1'b1;
            wr_data = cell_data + 8'd1;
          end
          OP_DEC: begin
            wr      = 1'b1;
            wr_data = cell_data - 8'd1;
          end
          OP_OUT: begin
            res_next.out_valid = 1'b1;
            res_next.out_byte  = cell_data;
          end
          OP_IN: begin
            wr      = 1'b1;
            wr_data = s1.input_byte;
          end
          OP_OPEN: begin
            if (cell_data == 8'd0) skip_next = 16'd1;
            else if (stack_count >= cnt_t'(STACK_DEPTH)) res_next.fault = FAULT_OVERFLOW;
            else push = 1'b1;
          end
          OP_CLOSE: begin
            if (stack_count == '0) res_next.fault = FAULT_EMPTY;
            else if (cell_data != 8'd0) res_next.next_position = stack_top;
            else pop = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // the next instruction reads the cell the pointer lands on after this one
  always_comb begin
    treq.rd_en   = accept;
    treq.rd_addr = ptr_upd;
    treq.wr_en   = wr && s1_advance;
    treq.wr_addr = ptr;
    treq.wr_data = wr_data;
    sop.push     = push && s1_advance;
    sop.pop      = pop && s1_advance;
    sop.data     = after;
  end

  bfc_tape u_tape (
    .clk     (clk),
    .rst     (rst),
    .req     (treq),
    .rd_data (cell_data),
    .busy    (tape_busy)
  );

  bfc_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .op    (sop),
    .count (stack_count),
    .top   (stack_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used_len     <= clamp_length(TAPE_LENGTH_RESET);
      s1_valid     <= 1'b0;
      ptr          <= '0;
      skip_depth   <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) used_len <= clamp_length(cfg_wdata);
      if (accept) s1_valid <= 1'b1;
      else if (s1_advance) s1_valid <= 1'b0;
      if (s1_advance) begin
        ptr        <= ptr_upd;
        skip_depth <= skip_next;
      end
      if (s1_advance) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= instr;
    if (s1_advance) result <= res_next;
  end

endmodule

[verif/tb_brainfuck_execution_core.sv]
// Self-checking testbench for brainfuck_execution_core: in-order result prediction and checking.
module tb_brainfuck_execution_core;
  import bfc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int IDLE_PCT    = 37;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        instr_valid = 1'b0;
  logic        instr_stall;
  instr_t      instr = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  brainfuck_execution_core DUT (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // interpreter state mirrored by the predictor
  logic [7:0]  tape_cells [TAPE_DEPTH];
  int unsigned cell_ptr;
  logic [15:0] loop_starts [STACK_DEPTH];
  int unsigned loop_count;
  logic [15:0] skip_level;
  logic [15:0] tape_len;

  instr_t  pending_instrs [$];
  result_t expected_results [$];
  bit          no_idle = 1'b0;
  logic [15:0] pc = '0;
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_out = 0;
  int n_overflow = 0;
  int n_empty = 0;

  function automatic result_t execute_instr(instr_t it);
    result_t     r;
    logic [15:0] after;
    int unsigned len;
    int unsigned p;
    after = it.position + 16'd1;
    r.next_position = after;
    r.out_valid = 1'b0;
    r.out_byte = 8'd0;
    r.fault = FAULT_NONE;
    len = tape_len;
    if (len < 1) len = 1;
    if (len > TAPE_DEPTH) len = TAPE_DEPTH;
    p = cell_ptr;
    if (skip_level != 16'd0) begin
      // skipping: only brackets move the nesting depth
      if (it.instruction == OP_OPEN) begin
        if (skip_level != 16'hFFFF) skip_level = skip_level + 16'd1;
      end else if (it.instruction == OP_CLOSE) begin
        skip_level = skip_level - 16'd1;
      end
    end else begin
      case (it.instruction)
        OP_RIGHT: p = (p + 1 >= len) ? 0 : p + 1;
        OP_LEFT:  p = (p == 0 || p > len) ? len - 1 : p - 1;
        OP_INC:   tape_cells[p] = tape_cells[p] + 8'd1;
        OP_DEC:   tape_cells[p] = tape_cells[p] - 8'd1;
        OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_byte = tape_cells[p];
        end
        OP_IN:    tape_cells[p] = it.input_byte;
        OP_OPEN: begin
          if (tape_cells[p] == 8'd0) begin
            skip_level = 16'd1;
          end else if (loop_count >= STACK_DEPTH) begin
            r.fault = FAULT_OVERFLOW;
          end else begin
            loop_starts[loop_count] = after;
            loop_count++;
          end
        end
        OP_CLOSE: begin
          if (loop_count == 0) begin
            r.fault = FAULT_EMPTY;
          end else if (tape_cells[p] != 8'd0) begin
            r.next_position = loop_starts[loop_count - 1];
          end else begin
            loop_count--;
          end
        end
        default: ;
      endcase
    end
    cell_ptr = p;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // driver: predicts each transfer, then presents the next pending instruction
  always @(posedge clk) begin : driver
    result_t pred;
    if (rst) begin
      instr_valid <= 1'b0;
    end else begin
      if (instr_valid && !instr_stall) begin
        pred = execute_instr(instr);
        expected_results.push_back(pred);
        if (pred.fault == FAULT_OVERFLOW) n_overflow++;
        if (pred.fault == FAULT_EMPTY) n_empty++;
      end
      if (!(instr_valid && instr_stall)) begin
        if (pending_instrs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          instr <= pending_instrs.pop_front();
          instr_valid <= 1'b1;
        end else begin
          instr_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: %h", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (want.out_valid) n_out++;
          if (result.next_position !== want.next_position) begin
            $display("%0t: next_position expected %h actual %h", $time,
                     want.next_position, result.next_position);
            errors++;
          end
          if (result.out_valid !== want.out_valid) begin
            $display("%0t: out_valid expected %b actual %b", $time,
                     want.out_valid, result.out_valid);
            errors++;
          end
          if (result.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     want.out_byte, result.out_byte);
            errors++;
          end
          if (result.fault !== want.fault) begin
            $display("%0t: fault expected %0d actual %0d", $time, want.fault, result.fault);
            errors++;
          end
        end
      end
      result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic emit(input logic [7:0] op, input logic [7:0] ib);
    instr_t it;
    it.instruction = op;
    it.position = pc;
    it.input_byte = ib;
    pending_instrs.push_back(it);
    pc = pc + 16'd1;
    n_sent++;
  endtask

  task automatic emit_op(input logic [7:0] op);
    emit(op, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(7))
      0: return OP_RIGHT;
      1: return OP_LEFT;
      2: return OP_INC;
      3: return OP_DEC;
      4: return OP_OUT;
      5: return OP_IN;
      6: return OP_OPEN;
      default: return OP_CLOSE;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c inside {OP_RIGHT, OP_LEFT, OP_INC, OP_DEC, OP_OUT, OP_IN, OP_OPEN, OP_CLOSE});
    return c;
  endfunction

  // set the cell to n, then replay n passes through the loop as a fetch unit would
  task automatic counted_loop();
    logic [7:0]  body [$];
    logic [15:0] top;
    int          n;
    n = $urandom_range(1, 4);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(3))
        0: body.push_back(OP_OUT);
        1: body = {body, OP_RIGHT, OP_INC, OP_LEFT};
        2: body = {body, OP_RIGHT, OP_DEC, OP_LEFT};
        default: body.push_back(noise_char());
      endcase
    end
    emit(OP_IN, 8'(n));
    emit_op(OP_OPEN);
    top = pc;
    repeat (n) begin
      pc = top;
      foreach (body[j]) emit_op(body[j]);
      emit_op(OP_DEC);
      emit_op(OP_CLOSE);
    end
  endtask

  // loop entered on a zero cell: its body, nested brackets included, is skipped
  task automatic skipped_loop();
    logic [7:0] c;
    emit(OP_IN, 8'd0);
    emit_op(OP_OPEN);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(3) == 0) begin
        emit_op(OP_OPEN);
        emit_op(noise_char());
        emit_op(OP_CLOSE);
      end else begin
        do c = pick_op(); while (c == OP_OPEN || c == OP_CLOSE);
        emit_op(c);
      end
    end
    emit_op(OP_CLOSE);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      counted_loop();
    end else if (r < 50) begin
      skipped_loop();
    end else if (r < 85) begin
      emit_op(pick_op());
    end else begin
      pc = 16'($urandom);
      emit_op(8'($urandom));
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_instrs.size() != 0 || instr_valid || expected_results.size() != 0);
  endtask

  task automatic write_length(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tape_len = v;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] lens [9];
    int start;
    foreach (tape_cells[i]) tape_cells[i] = 8'd0;
    foreach (loop_starts[i]) loop_starts[i] = 16'd0;
    cell_ptr = 0;
    loop_count = 0;
    skip_level = 16'd0;
    tape_len = TAPE_LENGTH_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset length: byte extremes, address wrap, empty stack, skip nesting
    emit_op(OP_OUT);
    emit(OP_IN, 8'hFF);
    emit_op(OP_INC);
    emit_op(OP_OUT);
    emit_op(OP_DEC);
    emit_op(OP_OUT);
    emit_op(OP_LEFT);
    emit(OP_IN, 8'h80);
    pc = 16'hFFFF;
    emit_op(OP_CLOSE);
    pc = 16'hFFFF;
    emit_op(OP_OPEN);
    emit_op(OP_CLOSE);
    emit(OP_IN, 8'h00);
    emit_op(OP_CLOSE);
    emit_op(OP_OPEN);
    emit_op(OP_OUT);
    emit_op(OP_OPEN);
    emit_op(OP_CLOSE);
    emit_op(OP_CLOSE);
    emit_op(OP_OUT);
    emit(8'h00, 8'h00);
    emit(8'hFF, 8'hFF);
    emit(OP_IN, 8'h7F);
    drain();

    // pointer left beyond a lowered length
    write_length(16'd5);
    emit_op(OP_INC);
    emit_op(OP_OUT);
    emit_op(OP_LEFT);
    drain();
    write_length(16'd0);
    emit_op(OP_RIGHT);
    emit_op(OP_LEFT);
    emit_op(OP_OUT);
    drain();
    write_length(16'hFFFF);
    emit_op(OP_LEFT);
    emit(OP_IN, 8'hA5);
    emit_op(OP_OUT);
    emit_op(OP_RIGHT);
    drain();

    // fill the loop stack past capacity, unwind it, then pop once too often
    emit(OP_IN, 8'd1);
    repeat (STACK_DEPTH + 1) emit_op(OP_OPEN);
    emit(OP_IN, 8'd0);
    repeat (STACK_DEPTH) emit_op(OP_CLOSE);
    emit_op(OP_CLOSE);
    drain();

    // deep skip nesting, full rate on both sides
    no_idle = 1'b1;
    emit(OP_IN, 8'd0);
    emit_op(OP_OPEN);
    repeat (60) emit_op(OP_OPEN);
    repeat (60) emit_op(OP_CLOSE);
    emit_op(OP_OUT);
    emit_op(OP_CLOSE);
    emit_op(OP_OUT);
    drain();
    no_idle = 1'b0;

    lens = '{16'd3, 16'd1, 16'd2, 16'd7, 16'd32768, 16'd16, 16'hFFFF, 16'd4,
             16'($urandom)};
    foreach (lens[i]) begin
      write_length(lens[i]);
      pc = 16'($urandom);
      start = n_sent;
      while (n_sent - start < 40) begin
        random_item();
        // hold the sender until the block has emptied, then resume
        if (i == 3 && n_sent - start >= 20 && n_sent - start < 26) drain();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("tb: %0d instructions checked, %0d output bytes, %0d overflow, %0d empty-stack faults",
             n_results, n_out, n_overflow, n_empty);
    $display("tb: tape lengths 0 to 65535, pointer past length, full loop stack, nested skip");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
